// ===== src/pfp_pkg.sv =====
// Shared constants and a helper function for the three-point plane solver.
// Used by every module of the block; depends on nothing.
package pfp_pkg;

    localparam int COORD_WIDTH_DEF = 32;
    localparam int NORM_FRAC       = 30;
    localparam int NORM_WIDTH      = 32;
    localparam int QUEUE_DEPTH     = 4;

    // Bit length of a magnitude up to 128 bits.
    function automatic logic [7:0] bitlen128(input logic [127:0] v);
        logic [7:0] n;
        n = 8'd0;
        for (int i = 0; i < 128; i++)
        begin
            if (v[i])
            begin
                n = 8'(i + 1);
            end
        end
        return n;
    endfunction

endpackage

// ===== src/pfp_front.sv =====
// Front part of the plane solver: edge vectors, cross product, magnitude
// and shift count; pipelined, one triple per beat. Depends on pfp_pkg.
module pfp_front #(
    parameter int COORD_WIDTH = pfp_pkg::COORD_WIDTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic signed [COORD_WIDTH-1:0] pt [9],
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [29:0]                   m_out [3],
    output logic [2:0]                    neg_out,
    output logic                          degen_out,
    output logic signed [COORD_WIDTH-1:0] p0_out [3]
);
    localparam int EW = COORD_WIDTH + 1;
    localparam int PW = 2 * EW;
    localparam int CW = PW + 1;

    logic                          v1_reg, v2_reg, v3_reg, v4_reg;
    logic signed [EW-1:0]          e1_reg [3], e2_reg [3];
    logic signed [COORD_WIDTH-1:0] p0a_reg [3], p0b_reg [3], p0c_reg [3], p0d_reg [3];
    logic signed [PW-1:0]          pr_reg [6];
    logic [127:0]                  mg_reg [3];
    logic [2:0]                    neg_reg;
    logic [2:0]                    ng_next;
    logic [127:0]                  mg_next [3];
    logic signed [CW-1:0]          cr [3];
    logic [127:0]                  orall;
    logic [7:0]                    len;
    logic [29:0]                   m_reg [3];
    logic [2:0]                    negc_reg;
    logic                          dg_reg;
    logic                          adv;

    // The whole pipe moves when the last stage may hand off.
    assign adv      = !v4_reg || out_ready;
    assign in_ready = adv;

    // Cross product terms from the registered products.
    always_comb
    begin
        cr[0] = CW'(pr_reg[0]) - CW'(pr_reg[1]);
        cr[1] = CW'(pr_reg[2]) - CW'(pr_reg[3]);
        cr[2] = CW'(pr_reg[4]) - CW'(pr_reg[5]);
        for (int i = 0; i < 3; i++)
        begin
            ng_next[i] = cr[i][CW-1];
            mg_next[i] = ng_next[i] ? 128'(-cr[i]) : 128'(cr[i]);
        end
    end

    // Normalizing shift: the largest magnitude lands on exactly 30 bits.
    always_comb
    begin
        orall = mg_reg[0] | mg_reg[1] | mg_reg[2];
        len   = pfp_pkg::bitlen128(orall);
    end

    // Pipeline registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < 3; i++)
            begin
                e1_reg[i]  <= EW'(pt[3+i]) - EW'(pt[i]);
                e2_reg[i]  <= EW'(pt[6+i]) - EW'(pt[i]);
                p0a_reg[i] <= pt[i];
                p0b_reg[i] <= p0a_reg[i];
                p0c_reg[i] <= p0b_reg[i];
                p0d_reg[i] <= p0c_reg[i];
            end
            pr_reg[0] <= e1_reg[1] * e2_reg[2];
            pr_reg[1] <= e1_reg[2] * e2_reg[1];
            pr_reg[2] <= e1_reg[2] * e2_reg[0];
            pr_reg[3] <= e1_reg[0] * e2_reg[2];
            pr_reg[4] <= e1_reg[0] * e2_reg[1];
            pr_reg[5] <= e1_reg[1] * e2_reg[0];
            mg_reg    <= mg_next;
            neg_reg   <= ng_next;
            negc_reg  <= neg_reg;
            dg_reg    <= (len == 8'd0);
            for (int i = 0; i < 3; i++)
            begin
                if (len > 8'd30)
                begin
                    m_reg[i] <= 30'(mg_reg[i] >> (len - 8'd30));
                end
                else
                begin
                    m_reg[i] <= 30'(mg_reg[i] << (8'd30 - len));
                end
            end
        end
    end

    assign out_valid = v4_reg;
    assign m_out     = m_reg;
    assign neg_out   = negc_reg;
    assign degen_out = dg_reg;
    assign p0_out    = p0d_reg;
endmodule

// ===== src/pfp_queue.sv =====
// Short queue between the front and back parts of the plane solver.
// Generic register FIFO with valid/ready sides. Depends on pfp_pkg.
module pfp_queue #(
    parameter int WIDTH = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [WIDTH-1:0] in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [WIDTH-1:0] out_data
);
    localparam int D  = pfp_pkg::QUEUE_DEPTH;
    localparam int AW = $clog2(D);

    logic [WIDTH-1:0] mem [D];
    logic [AW-1:0]    wr_reg, rd_reg;
    logic [AW:0]      cnt_reg;
    logic             push, pop;

    assign in_ready  = (cnt_reg != (AW+1)'(D));
    assign out_valid = (cnt_reg != '0);
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;
    assign out_data  = mem[rd_reg];

    // Pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_reg <= wr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_reg <= rd_reg + 1'b1;
            end
            cnt_reg <= cnt_reg + (AW+1)'(push) - (AW+1)'(pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_reg] <= in_data;
        end
    end
endmodule

// ===== src/pfp_back.sv =====
// Back part of the plane solver: pipelined square root, divisions and
// the plane offset; one triple per beat. Depends on pfp_pkg.
module pfp_back #(
    parameter int COORD_WIDTH = pfp_pkg::COORD_WIDTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [29:0]                   m_in [3],
    input  logic [2:0]                    neg_in,
    input  logic                          degen_in,
    input  logic signed [COORD_WIDTH-1:0] p0_in [3],
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic signed [31:0]            nx,
    output logic signed [31:0]            ny,
    output logic signed [31:0]            nz,
    output logic signed [COORD_WIDTH-1:0] dout,
    output logic                          degen
);
    localparam int SQ = 32;          // root steps, 2 bits each of a 64-bit sum
    localparam int DV = 61;          // quotient bits of a 61-bit dividend
    localparam int NS = 3 + SQ + DV + 5;
    localparam int TW = COORD_WIDTH + 36;
    localparam int SH = TW - 30;

    // Per-item payload carried alongside the arithmetic.
    typedef struct packed {
        logic [2:0]                    neg;
        logic                          dg;
        logic [COORD_WIDTH*3-1:0]      p0;
    } side_t;

    logic          v_reg [NS];
    side_t         sd_reg [NS];
    logic          adv;

    // Square root pipeline state.
    logic [59:0]   sq_reg [3];
    logic [63:0]   rx_reg [SQ+1];
    logic [63:0]   rr_reg [SQ+1];
    logic [29:0]   mq_reg [SQ+2][3];
    logic [31:0]   root_reg;
    logic [29:0]   md_reg [3];
    // Division pipeline state.
    logic [60:0]   dn_reg [DV+1][3];
    logic [61:0]   rm_reg [DV+1][3];
    logic [60:0]   qt_reg [DV+1][3];
    logic [31:0]   rt_reg [DV+1];
    logic signed [31:0] n_reg [3];
    logic signed [31:0] nh_reg [3][3];
    logic signed [TW-1:0] pp_reg [3];
    logic signed [TW-1:0] t_reg;
    logic signed [COORD_WIDTH-1:0] d_reg;

    assign adv      = !v_reg[NS-1] || out_ready;
    assign in_ready = adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < NS; s++)
            begin
                v_reg[s] <= 1'b0;
            end
        end
        else if (adv)
        begin
            v_reg[0] <= in_valid;
            for (int s = 1; s < NS; s++)
            begin
                v_reg[s] <= v_reg[s-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sd_reg[0] <= '{neg: neg_in, dg: degen_in,
                           p0: {p0_in[2], p0_in[1], p0_in[0]}};
            for (int s = 1; s < NS; s++)
            begin
                sd_reg[s] <= sd_reg[s-1];
            end

            // Squares, then their sum.
            for (int i = 0; i < 3; i++)
            begin
                sq_reg[i]    <= 60'(m_in[i]) * 60'(m_in[i]);
                mq_reg[0][i] <= m_in[i];
            end
            rx_reg[0] <= 64'(sq_reg[0]) + 64'(sq_reg[1]) + 64'(sq_reg[2]);
            rr_reg[0] <= '0;
            mq_reg[1] <= mq_reg[0];

            // Digit-by-digit square root, one result bit per stage.
            for (int k = 0; k < SQ; k++)
            begin
                logic [63:0] bt;
                bt = 64'd1 << (62 - 2 * k);
                if (rx_reg[k] >= rr_reg[k] + bt)
                begin
                    rx_reg[k+1] <= rx_reg[k] - (rr_reg[k] + bt);
                    rr_reg[k+1] <= (rr_reg[k] >> 1) + bt;
                end
                else
                begin
                    rx_reg[k+1] <= rx_reg[k];
                    rr_reg[k+1] <= rr_reg[k] >> 1;
                end
                mq_reg[k+2] <= mq_reg[k+1];
            end
            root_reg <= 32'(rr_reg[SQ]);
            md_reg   <= mq_reg[SQ+1];

            // Restoring divisions, one quotient bit per stage.
            rt_reg[0] <= root_reg;
            for (int i = 0; i < 3; i++)
            begin
                dn_reg[0][i] <= {1'b0, md_reg[i], 30'd0} + 61'(root_reg >> 1);
                rm_reg[0][i] <= '0;
                qt_reg[0][i] <= '0;
            end
            for (int k = 0; k < DV; k++)
            begin
                rt_reg[k+1] <= rt_reg[k];
                for (int i = 0; i < 3; i++)
                begin
                    logic [61:0] tr;
                    tr = {rm_reg[k][i][60:0], dn_reg[k][i][60]};
                    dn_reg[k+1][i] <= dn_reg[k][i] << 1;
                    if (tr >= 62'(rt_reg[k]))
                    begin
                        rm_reg[k+1][i] <= tr - 62'(rt_reg[k]);
                        qt_reg[k+1][i] <= {qt_reg[k][i][59:0], 1'b1};
                    end
                    else
                    begin
                        rm_reg[k+1][i] <= tr;
                        qt_reg[k+1][i] <= {qt_reg[k][i][59:0], 1'b0};
                    end
                end
            end

            // Clamp and sign the normal.
            for (int i = 0; i < 3; i++)
            begin
                logic [31:0] q;
                if (sd_reg[NS-5].dg)
                begin
                    q = '0;
                end
                else if (qt_reg[DV][i] > 61'(32'd1 << 30))
                begin
                    q = 32'd1 << 30;
                end
                else
                begin
                    q = 32'(qt_reg[DV][i]);
                end
                n_reg[i] <= sd_reg[NS-5].neg[i] ? -$signed(q) : $signed(q);
            end

            // Offset products, sum, round and saturate; the normal waits alongside.
            for (int i = 0; i < 3; i++)
            begin
                pp_reg[i] <= TW'(n_reg[i]) *
                    TW'($signed(sd_reg[NS-4].p0[i*COORD_WIDTH +: COORD_WIDTH]));
                nh_reg[0][i] <= n_reg[i];
            end
            nh_reg[1] <= nh_reg[0];
            nh_reg[2] <= nh_reg[1];
            t_reg <= (TW'(1) <<< 29) - pp_reg[0] - pp_reg[1] - pp_reg[2];
            begin
                logic signed [SH-1:0] dv;
                dv = SH'(t_reg >>> 30);
                if (dv > SH'((COORD_WIDTH'(1) << (COORD_WIDTH-1)) - 1'b1)
                    && !dv[SH-1])
                begin
                    d_reg <= {1'b0, {(COORD_WIDTH-1){1'b1}}};
                end
                else if (dv < -(SH'(1) <<< (COORD_WIDTH-1)))
                begin
                    d_reg <= {1'b1, {(COORD_WIDTH-1){1'b0}}};
                end
                else
                begin
                    d_reg <= COORD_WIDTH'(dv);
                end
            end
        end
    end

    assign out_valid = v_reg[NS-1];
    assign nx        = nh_reg[2][0];
    assign ny        = nh_reg[2][1];
    assign nz        = nh_reg[2][2];
    assign dout      = sd_reg[NS-1].dg ? '0 : d_reg;
    assign degen     = sd_reg[NS-1].dg;
endmodule

// ===== src/plane_from_three_points.sv =====
// Plane through three points: edge vectors, cross product, unit normal
// in Q2.30 and saturated offset. Top level; depends on pfp_pkg and the
// pfp_front, pfp_queue and pfp_back modules.
//
// Usage: the slave group (s_axis_*) takes one point triple per beat, nine
// signed coordinates packed in tdata, p0_x in the lowest bits. The master
// group (m_axis_*) gives one result beat per triple in order: normal_x,
// normal_y, normal_z, offset_d in tdata and the degenerate flag in tuser.
// Throughput is one triple per cycle when nothing stalls. From the accepting
// edge to the result beat, four front stages form the edge vectors, cross
// product and normalizing shift, the queue adds one, and the back takes
// 101: squares, their sum, one stage per root bit (32), the root and
// division setup, one stage per quotient bit (61) and four for the
// normal, the offset products, their sum and saturation.
// The front and back pipelines are parted by a four-entry queue; each
// pipeline holds while its own output is stalled, so a stalled receiver
// backs up into the queue and then drops s_axis_tready.
// Reset clears all valid flags; no result is pending after reset.
module plane_from_three_points #(
    parameter int COORD_WIDTH = pfp_pkg::COORD_WIDTH_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // p0_x, p0_y, p0_z, p1_x, p1_y, p1_z, p2_x, p2_y, p2_z, zero fill
    input  logic [((9*COORD_WIDTH+7)/8)*8-1:0] s_axis_tdata,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // normal_x, normal_y, normal_z, offset_d, zero fill
    output logic [((96+COORD_WIDTH+7)/8)*8-1:0] m_axis_tdata,
    // degenerate
    output logic                             m_axis_tuser
);
    localparam int OW = ((96 + COORD_WIDTH + 7) / 8) * 8;
    localparam int QW = 90 + 3 + 1 + 3 * COORD_WIDTH;

    logic signed [COORD_WIDTH-1:0] pt [9];
    logic                          fv, fr, bv, br;
    logic [29:0]                   fm [3], bm [3];
    logic [2:0]                    fneg, bneg;
    logic                          fdg, bdg;
    logic signed [COORD_WIDTH-1:0] fp0 [3], bp0 [3];
    logic [QW-1:0]                 qin, qout;
    logic signed [31:0]            nx, ny, nz;
    logic signed [COORD_WIDTH-1:0] d;

    // Unpack the coordinates.
    always_comb
    begin
        for (int i = 0; i < 9; i++)
        begin
            pt[i] = s_axis_tdata[i*COORD_WIDTH +: COORD_WIDTH];
        end
    end

    pfp_front #(.COORD_WIDTH(COORD_WIDTH)) u_front (
        .clk, .rst_n,
        .in_valid(s_axis_tvalid), .in_ready(s_axis_tready), .pt(pt),
        .out_valid(fv), .out_ready(fr),
        .m_out(fm), .neg_out(fneg), .degen_out(fdg), .p0_out(fp0)
    );

    assign qin = {fp0[2], fp0[1], fp0[0], fdg, fneg, fm[2], fm[1], fm[0]};

    pfp_queue #(.WIDTH(QW)) u_queue (
        .clk, .rst_n,
        .in_valid(fv), .in_ready(fr), .in_data(qin),
        .out_valid(bv), .out_ready(br), .out_data(qout)
    );

    assign {bp0[2], bp0[1], bp0[0], bdg, bneg, bm[2], bm[1], bm[0]} = qout;

    pfp_back #(.COORD_WIDTH(COORD_WIDTH)) u_back (
        .clk, .rst_n,
        .in_valid(bv), .in_ready(br),
        .m_in(bm), .neg_in(bneg), .degen_in(bdg), .p0_in(bp0),
        .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
        .nx(nx), .ny(ny), .nz(nz), .dout(d), .degen(m_axis_tuser)
    );

    assign m_axis_tdata = OW'({d, nz, ny, nx});
endmodule

// ===== src/pfp_checker.sv =====
// Port-level checks for the plane solver, bound to the top level.
// Depends on plane_from_three_points only through its ports.
module pfp_checker #(
    parameter int COORD_WIDTH = pfp_pkg::COORD_WIDTH_DEF
) (
    input logic                                  clk,
    input logic                                  rst_n,
    input logic                                  m_axis_tvalid,
    input logic                                  m_axis_tready,
    input logic [((96+COORD_WIDTH+7)/8)*8-1:0]   m_axis_tdata,
    input logic                                  m_axis_tuser
);
    // A stalled result beat holds.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result beat changed while stalled");

    // A degenerate result carries all-zero coefficients.
    a_degen: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == '0)
        else $error("degenerate result with nonzero coefficients");

    // A plane normal is never all zero.
    a_nz: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata[95:0] != '0)
        else $error("zero normal on a valid plane");
endmodule

bind plane_from_three_points pfp_checker #(.COORD_WIDTH(COORD_WIDTH)) u_pfp_checker (
    .clk, .rst_n, .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser
);
